// ----- hdl/bitmap_allocation_map_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap allocation map assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ALLOCATION_MAP_DEFINES_SVH
`define BITMAP_ALLOCATION_MAP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bam_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap allocation map package
// Word types, command and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package bam_pkg;

    localparam int IDX_W     = 12;
    localparam int LEN_W     = 13;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int IDX_REACH = 4096;

    localparam logic [CMD_W-1:0] CMD_GET         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET         = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_RANGE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_RANGE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND        = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
    } req_word_t;

    typedef struct packed {
        logic                bit_value;
        logic [IDX_W-1:0]    found_index;
        logic [STATUS_W-1:0] status;
    } rsp_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

// ----- hdl/bitmap_allocation_map.sv -----
// Bitmap allocation map with find-first-clear.
//
// Request words arrive on req_valid/req_stall/req_data, one result word per
// request leaves on rsp_valid/rsp_stall/rsp_data. A word moves at a rising edge
// with valid high and stall low. The user must write the map length register on
// cfg_valid/cfg_ready/cfg_data only while no request is in flight (not enforced).
//
// The map sits in one synchronous RAM of WORD_BITS-bit words. A request that
// is not rejected reads its first word at acceptance and then visits one word
// at a time: get, set and clear visit one word; a range command or clear-all
// visits the words it covers; find visits the words up to the first one with
// a clear bit (at most the words of the map in use). The next request is taken
// in the cycle after the result is registered.
//
// After reset the RAM is zeroed, one word a cycle, through all of its words
// (64 with the default parameters); requests stall meanwhile. A result waits
// in the output register while rsp_stall is high; the block then stalls only
// if a later request finishes before it is taken.
// ----------------------------------------------------------------------------
// Bitmap allocation map top level
// Read-modify-write sequencer around the bit map RAM.
// ----------------------------------------------------------------------------
`include "bitmap_allocation_map_defines.svh"

module bitmap_allocation_map
    import bam_pkg::*;
#(
    parameter int BITS      = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_word_t        req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_word_t        rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    // Only indices that the request fields can reach get storage.
    localparam int LIMIT   = (BITS < IDX_REACH) ? BITS : IDX_REACH;
    localparam int DEPTH   = (LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int WB_LOG2 = $clog2(WORD_BITS);
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    map_length_reg;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic                skip_reg, skip_next;
    logic [STATUS_W-1:0] skip_status_reg, skip_status_next;
    logic [AW-1:0]       cur_addr_reg, cur_addr_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_data_reg, rsp_data_next;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [LEN_W-1:0]     len;
    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic                 is_last;
    logic [AW-1:0]        first_addr, last_addr;
    logic [WORD_BITS-1:0] lo_mask, hi_mask, word_mask, cand;
    logic [WB_LOG2-1:0]   enc;
    logic                 set_op;

    assign len       = (map_length_reg > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : map_length_reg;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign first_addr = lo_reg[WB_LOG2 +: AW];
    assign last_addr  = hi_reg[WB_LOG2 +: AW];
    assign is_last    = (cur_addr_reg == last_addr);

    // Bits of the current word that fall inside [lo, hi].
    assign lo_mask   = (cur_addr_reg == first_addr)
                     ? ({WORD_BITS{1'b1}} << lo_reg[WB_LOG2-1:0]) : {WORD_BITS{1'b1}};
    assign hi_mask   = is_last
                     ? ({WORD_BITS{1'b1}} >> (WB_LOG2'(WORD_BITS - 1) - hi_reg[WB_LOG2-1:0]))
                     : {WORD_BITS{1'b1}};
    assign word_mask = lo_mask & hi_mask;
    assign cand      = ~rd_data_reg & hi_mask;
    assign set_op    = (cmd_reg == CMD_SET) || (cmd_reg == CMD_SET_RANGE);

    always_comb
    begin
        enc = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                enc = WB_LOG2'(j);
            end
        end
    end

    // Request decode: range check and the span of words to visit.
    always_comb
    begin
        cmd_next         = req_data.command;
        lo_next          = req_data.first_index;
        hi_next          = req_data.first_index;
        skip_next        = 1'b0;
        skip_status_next = STATUS_OK;
        unique case (req_data.command) inside
            CMD_GET, CMD_SET, CMD_CLEAR:
            begin
                if ({1'b0, req_data.first_index} >= len)
                begin
                    skip_next        = 1'b1;
                    skip_status_next = STATUS_BAD;
                end
            end
            CMD_SET_RANGE, CMD_CLEAR_RANGE:
            begin
                hi_next = req_data.last_index;
                if (({1'b0, req_data.last_index} >= len) ||
                    (req_data.first_index > req_data.last_index))
                begin
                    skip_next        = 1'b1;
                    skip_status_next = STATUS_BAD;
                end
            end
            CMD_CLEAR_ALL, CMD_FIND:
            begin
                lo_next = '0;
                hi_next = IDX_W'(len - LEN_W'(1));
                if (len == '0)
                begin
                    skip_next        = 1'b1;
                    skip_status_next = (req_data.command == CMD_FIND) ? STATUS_NONE : STATUS_OK;
                end
            end
            default:
            begin
                skip_next        = 1'b1;
                skip_status_next = STATUS_BAD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control per state.
    always_comb
    begin
        finish         = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cur_addr_reg;
        mem_raddr      = cur_addr_reg + AW'(1);
        mem_wdata      = set_op ? (rd_data_reg | word_mask) : (rd_data_reg & ~word_mask);
        cur_addr_next  = cur_addr_reg;
        clr_addr_next  = clr_addr_reg;
        rsp_data_next  = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                mem_raddr     = lo_next[WB_LOG2 +: AW];
                mem_re        = accept && !skip_next;
                cur_addr_next = lo_next[WB_LOG2 +: AW];
            end
            ST_WALK:
            begin
                if (skip_reg)
                begin
                    finish               = 1'b1;
                    rsp_data_next.status = skip_status_reg;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_GET:
                        begin
                            finish                  = 1'b1;
                            rsp_data_next.bit_value = rd_data_reg[lo_reg[WB_LOG2-1:0]];
                        end
                        CMD_FIND:
                        begin
                            if (cand != '0)
                            begin
                                finish                    = 1'b1;
                                rsp_data_next.found_index = IDX_W'({cur_addr_reg, enc});
                            end
                            else if (is_last)
                            begin
                                finish               = 1'b1;
                                rsp_data_next.status = STATUS_NONE;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                cur_addr_next = cur_addr_reg + AW'(1);
                            end
                        end
                        default:
                        begin
                            // Set, clear, ranges and clear-all: masked update per word.
                            finish = is_last;
                            mem_we = !is_last || out_free;
                            if (!is_last)
                            begin
                                mem_re        = 1'b1;
                                cur_addr_next = cur_addr_reg + AW'(1);
                            end
                        end
                    endcase
                end
                if (finish && out_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            map_length_reg <= LEN_W'(IDX_REACH);
            clr_addr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                map_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        if (accept)
        begin
            cmd_reg         <= cmd_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            skip_reg        <= skip_next;
            skip_status_reg <= skip_status_next;
        end
        if (state_reg == ST_WALK && finish && out_free)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    `BAM_ASSERT_NOW(a_no_rw_collision, mem_we && mem_re, mem_waddr != mem_raddr,
                    "RAM read and write hit the same word")
    `BAM_ASSERT_NOW(a_walk_in_span, (state_reg == ST_WALK) && !skip_reg,
                    cur_addr_reg <= last_addr, "word walk ran past the last word")
    `BAM_ASSERT_NOW(a_clear_done, (state_reg == ST_CLEAR) && (state_next == ST_IDLE),
                    clr_addr_reg == AW'(DEPTH - 1), "clearing pass left early")
    `BAM_ASSERT_NEXT(a_result_from_walk, (state_reg != ST_WALK) && !rsp_valid_reg,
                     !rsp_valid_reg, "result appeared outside a walk")

endmodule
